// ===== rtl/emut_pkg.sv =====
// ----------------------------------------------------------------------------
// emut_pkg
// Shared types, sizes and helpers for the min-extracting unsorted table.
// ----------------------------------------------------------------------------
package emut_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int FIELD_W     = 32;
    localparam int COUNT_OUT_W = 7;
    localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);

    typedef logic [VALUE_WIDTH-1:0] entry_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [COUNT_W-1:0]     count_t;

    typedef enum logic
    {
        KIND_APPEND = 1'b0,
        KIND_DELMIN = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_MOVE
    } state_t;

    // Table port request from sequencer to storage
    typedef struct packed
    {
        logic   we;
        addr_t  waddr;
        entry_t wdata;
        logic   re;
        addr_t  raddr;
    } mem_req_t;

    // Finished result word handed to the output register
    typedef struct packed
    {
        logic                      valid;
        logic signed [FIELD_W-1:0] removed;
        status_t                   status;
        logic [COUNT_OUT_W-1:0]    count;
    } result_t;

    function automatic entry_t to_entry(input logic signed [FIELD_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic signed [FIELD_W-1:0] to_field(input entry_t v);
        logic signed [63:0] w;
        w = 64'(signed'(v));
        return w[FIELD_W-1:0];
    endfunction

endpackage

// ===== rtl/emut_table.sv =====
// ----------------------------------------------------------------------------
// emut_table
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module emut_table
(
    input  logic               clk,
    input  emut_pkg::mem_req_t req,
    output emut_pkg::entry_t   rdata
);

    emut_pkg::entry_t mem [emut_pkg::CAPACITY];
    emut_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        // hold read data while no read is issued
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/emut_seq.sv =====
// ----------------------------------------------------------------------------
// emut_seq
// Sequencer: entry count, append, linear minimum scan and last-entry move.
// ----------------------------------------------------------------------------
module emut_seq
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   kind,
    input  logic signed [emut_pkg::FIELD_W-1:0]    value,
    input  logic                                   out_free,
    input  emut_pkg::entry_t                       rdata,
    output emut_pkg::mem_req_t                     req,
    output emut_pkg::result_t                      res
);

    emut_pkg::state_t state_reg, state_next;
    emut_pkg::count_t count_reg, count_next;
    emut_pkg::count_t issue_idx_reg, issue_idx_next;
    emut_pkg::addr_t  cmp_idx_reg, cmp_idx_next;
    emut_pkg::addr_t  best_idx_reg, best_idx_next;
    emut_pkg::entry_t best_val_reg, best_val_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic             take;
    logic             scan_done;
    emut_pkg::addr_t  last;
    emut_pkg::count_t count_dec;

    assign full      = (count_reg == emut_pkg::COUNT_W'(emut_pkg::CAPACITY));
    assign empty     = (count_reg == '0);
    assign count_dec = count_reg - emut_pkg::COUNT_W'(1);
    assign last      = count_dec[emut_pkg::ADDR_W-1:0];
    assign in_stall  = !((state_reg == emut_pkg::S_IDLE) && out_free);
    assign accept    = in_valid && !in_stall;
    assign scan_done = (cmp_idx_reg == last);
    assign take      = (cmp_idx_reg == '0) || ($signed(rdata) < $signed(best_val_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            emut_pkg::S_IDLE:
            begin
                if (accept && (kind == emut_pkg::KIND_DELMIN) && !empty)
                begin
                    state_next = emut_pkg::S_SCAN;
                end
            end
            emut_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = emut_pkg::S_MOVE;
                end
            end
            emut_pkg::S_MOVE:
            begin
                if (out_free)
                begin
                    state_next = emut_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = emut_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        issue_idx_next = issue_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        best_idx_next  = best_idx_reg;
        best_val_next  = best_val_reg;
        req            = '0;
        res            = '0;
        res.status     = emut_pkg::ST_OK;
        unique case (state_reg)
            emut_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == emut_pkg::KIND_APPEND)
                    begin
                        res.valid = 1'b1;
                        if (full)
                        begin
                            res.status = emut_pkg::ST_FULL;
                        end
                        else
                        begin
                            req.we     = 1'b1;
                            req.waddr  = count_reg[emut_pkg::ADDR_W-1:0];
                            req.wdata  = emut_pkg::to_entry(value);
                            count_next = count_reg + emut_pkg::COUNT_W'(1);
                        end
                        res.count = emut_pkg::COUNT_OUT_W'(count_next);
                    end
                    else if (empty)
                    begin
                        res.valid  = 1'b1;
                        res.status = emut_pkg::ST_EMPTY;
                        res.count  = emut_pkg::COUNT_OUT_W'(count_reg);
                    end
                    else
                    begin
                        // start the scan at entry zero
                        req.re         = 1'b1;
                        req.raddr      = '0;
                        issue_idx_next = emut_pkg::COUNT_W'(1);
                        cmp_idx_next   = '0;
                    end
                end
            end
            emut_pkg::S_SCAN:
            begin
                // read the next entry, or past the end fetch the last entry for the move
                req.re         = 1'b1;
                req.raddr      = (issue_idx_reg < count_reg)
                               ? issue_idx_reg[emut_pkg::ADDR_W-1:0] : last;
                issue_idx_next = issue_idx_reg + emut_pkg::COUNT_W'(1);
                cmp_idx_next   = cmp_idx_reg + emut_pkg::ADDR_W'(1);
                if (take)
                begin
                    best_idx_next = cmp_idx_reg;
                    best_val_next = rdata;
                end
            end
            emut_pkg::S_MOVE:
            begin
                if (out_free)
                begin
                    req.we      = 1'b1;
                    req.waddr   = best_idx_reg;
                    req.wdata   = rdata;
                    count_next  = count_dec;
                    res.valid   = 1'b1;
                    res.removed = emut_pkg::to_field(best_val_reg);
                    res.count   = emut_pkg::COUNT_OUT_W'(count_dec);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= emut_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        best_idx_reg  <= best_idx_next;
        best_val_reg  <= best_val_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= emut_pkg::COUNT_W'(emut_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == emut_pkg::S_SCAN) |-> (!empty && (cmp_idx_reg <= last)))
        else $error("scan index outside entries in use");

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> out_free)
        else $error("result produced with output slot occupied");

    a_move_dec: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == emut_pkg::S_MOVE) && out_free)
        |=> (count_reg == $past(count_dec)) && (state_reg == emut_pkg::S_IDLE))
        else $error("delete-min did not retire one entry");

endmodule

// ===== rtl/extract_min_unsorted_table.sv =====
// ----------------------------------------------------------------------------
// extract_min_unsorted_table
// Unordered table of signed values with append and delete-minimum.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one word: kind and value.
// kind 0 appends value at the end of the table, or reports full when the
// table already holds CAPACITY entries. kind 1 removes and returns the
// smallest entry (lowest index on ties), moves the last entry into its slot,
// or reports empty. Output channel (out_valid / out_stall) returns exactly
// one word per input word: removed_value, status, count_after.
// An append or an error answers from the idle state; a delete-min over n
// entries is paced by the single read port of the table, which the scan
// walks one entry per cycle, followed by the move of the last entry.
// One word is worked on at a time; the next is taken once the previous
// result has left the output register or is leaving it in that cycle.
// Reset empties the table (count to zero); the entries need no clearing.
// While out_stall is high and a result word waits, it holds and no new word is taken.
// ----------------------------------------------------------------------------
module extract_min_unsorted_table
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic signed [emut_pkg::FIELD_W-1:0] value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [emut_pkg::FIELD_W-1:0] removed_value,
    output logic [1:0]                          status,
    output logic [emut_pkg::COUNT_OUT_W-1:0]    count_after
);

    emut_pkg::mem_req_t req;
    emut_pkg::entry_t   rdata;
    emut_pkg::result_t  res;
    logic               out_free;

    logic                                out_valid_reg;
    logic signed [emut_pkg::FIELD_W-1:0] removed_reg;
    emut_pkg::status_t                   status_reg;
    logic [emut_pkg::COUNT_OUT_W-1:0]    count_reg;

    assign out_free = !out_valid_reg || !out_stall;

    emut_table u_table
    (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    emut_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .value    (value),
        .out_free (out_free),
        .rdata    (rdata),
        .req      (req),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            // drop the word once taken
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            removed_reg <= res.removed;
            status_reg  <= res.status;
            count_reg   <= res.count;
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_reg;
    assign status        = status_reg;
    assign count_after   = count_reg;

endmodule
